// ----- design/atq_pkg.sv -----
// Shared types, command codes and constants of the alarm timer queue.
package atq_pkg;

	localparam logic [2:0] KIND_ARM    = 3'd0;
	localparam logic [2:0] KIND_DISARM = 3'd1;
	localparam logic [2:0] KIND_ADD    = 3'd2;
	localparam logic [2:0] KIND_SUB    = 3'd3;
	localparam logic [2:0] KIND_UPDATE = 3'd4;

	localparam int          MAX_FIRE   = 32;
	localparam int          FIRE_CNT_W = 6;
	localparam logic [31:0] TICK_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  owner;
		logic [1:0]  alarm_number;
		logic [31:0] amount;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  fired_owner;
		logic [1:0]  fired_alarm;
		logic [31:0] fired_deadline;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SHIFT,
		ST_SCAN,
		ST_DRAIN,
		ST_PASS_END,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic arm_wr;
		logic disarm;
		logic shift_rd;
		logic shift_wr;
		logic scan_init;
		logic scan_rd;
		logic fire;
		logic emit;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       addr_ok;
		logic       slot_armed;
		logic       scan_last;
		logic       best_valid;
		logic       fire_at_limit;
		logic       pend_valid;
	} status_t;

endpackage

// ----- design/atq_ctrl.sv -----
// Controller state machine of the alarm timer queue.
module atq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  atq_pkg::status_t status,
	output atq_pkg::cmd_t   cmd,
	output logic            busy
);
	import atq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_nxt = ST_IDLE;
				unique case (status.kind)
					KIND_ARM: begin
						cmd.arm_wr = status.addr_ok;
					end
					KIND_DISARM: begin
						cmd.disarm = status.addr_ok;
					end
					KIND_ADD, KIND_SUB: begin
						if (status.addr_ok && status.slot_armed) begin
							cmd.shift_rd = 1'b1;
							state_nxt    = ST_SHIFT;
						end
					end
					KIND_UPDATE: begin
						cmd.scan_init = 1'b1;
						state_nxt     = ST_SCAN;
					end
					default: begin
						state_nxt = ST_IDLE;
					end
				endcase
			end
			ST_SHIFT: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_PASS_END;
			end
			ST_PASS_END: begin
				// previous winner goes out now; it is final if this pass found none
				cmd.emit      = status.pend_valid;
				cmd.emit_last = !status.best_valid;
				if (status.best_valid) begin
					cmd.fire = 1'b1;
					if (status.fire_at_limit) begin
						state_nxt = ST_FINAL;
					end else begin
						cmd.scan_init = 1'b1;
						state_nxt     = ST_SCAN;
					end
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_FINAL: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = 1'b1;
				state_nxt     = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/atq_dp.sv -----
// Datapath of the alarm timer queue: slot memory, armed bits, scan and selection.
module atq_dp #(
	parameter int OWNERS           = 8,
	parameter int ALARMS_PER_OWNER = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  atq_pkg::in_item_t item,
	input  atq_pkg::cmd_t     cmd,
	output atq_pkg::status_t  status,
	output logic              fired,
	output atq_pkg::out_item_t result
);
	import atq_pkg::*;

	localparam int SLOTS  = OWNERS * ALARMS_PER_OWNER;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OWN_W  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
	localparam int ALM_W  = (ALARMS_PER_OWNER > 1) ? $clog2(ALARMS_PER_OWNER) : 1;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [OWN_W-1:0] o,
	                                              input logic [ALM_W-1:0] a);
		return SLOT_W'(int'(o) * ALARMS_PER_OWNER + int'(a));
	endfunction

	// captured item
	in_item_t          item_q;
	logic [SLOT_W-1:0] slot;
	logic              addr_ok;

	// slot memory: {deadline, stamp}
	logic [63:0]       mem_q [SLOTS];
	logic [63:0]       rd_data_q;
	logic [63:0]       mem_wdata;
	logic              mem_we;
	logic              mem_re;
	logic [SLOT_W-1:0] rd_addr;
	logic [31:0]       rd_dl;
	logic [31:0]       rd_stamp;

	logic [SLOTS-1:0]  armed_q;
	logic [31:0]       counter_q;

	// saturating shift arithmetic
	logic [31:0]       add_a;
	logic [32:0]       add_sum;
	logic [31:0]       add_sat;
	logic [31:0]       sub_sat;
	logic [31:0]       new_dl;

	// scan
	logic [OWN_W-1:0]  scan_own_q;
	logic [ALM_W-1:0]  scan_alm_q;
	logic              scan_last;
	logic              rd_vld_s1;
	logic [OWN_W-1:0]  own_s1;
	logic [ALM_W-1:0]  alm_s1;
	logic [31:0]       age;
	logic              cand;
	logic              better;

	logic              best_vld_q;
	logic [OWN_W-1:0]  best_own_q;
	logic [ALM_W-1:0]  best_alm_q;
	logic [31:0]       best_dl_q;
	logic [31:0]       best_age_q;

	logic              pend_vld_q;
	logic [OWN_W-1:0]  pend_own_q;
	logic [ALM_W-1:0]  pend_alm_q;
	logic [31:0]       pend_dl_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	logic              fired_q;
	out_item_t         result_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	assign addr_ok = (int'(item_q.owner) < OWNERS) &&
	                 (int'(item_q.alarm_number) < ALARMS_PER_OWNER);
	assign slot    = slot_of(OWN_W'(item_q.owner), ALM_W'(item_q.alarm_number));

	// one adder serves arm (now + delay) and add time (deadline + amount)
	assign rd_dl    = rd_data_q[63:32];
	assign rd_stamp = rd_data_q[31:0];
	assign add_a    = cmd.arm_wr ? item_q.now : rd_dl;
	assign add_sum  = {1'b0, add_a} + {1'b0, item_q.amount};
	assign add_sat  = add_sum[32] ? TICK_MAX : add_sum[31:0];
	assign sub_sat  = (item_q.amount > rd_dl) ? 32'd0 : (rd_dl - item_q.amount);
	assign new_dl   = (cmd.shift_wr && (item_q.kind == KIND_SUB)) ? sub_sat : add_sat;

	assign mem_we    = cmd.arm_wr || cmd.shift_wr;
	assign mem_wdata = {new_dl, counter_q};
	assign mem_re    = cmd.scan_rd || cmd.shift_rd;
	assign rd_addr   = cmd.scan_rd ? slot_of(scan_own_q, scan_alm_q) : slot;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[slot] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= '0;
			counter_q <= '0;
		end else begin
			if (mem_we) begin
				counter_q <= counter_q + 32'd1;
			end
			if (cmd.arm_wr) begin
				armed_q[slot] <= 1'b1;
			end else if (cmd.disarm) begin
				armed_q[slot] <= 1'b0;
			end else if (cmd.fire) begin
				armed_q[slot_of(best_own_q, best_alm_q)] <= 1'b0;
			end
		end
	end

	// scan counters walk alarm number inside owner
	assign scan_last = (scan_own_q == OWN_W'(OWNERS - 1)) &&
	                   (scan_alm_q == ALM_W'(ALARMS_PER_OWNER - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_own_q <= '0;
			scan_alm_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_init) begin
				scan_own_q <= '0;
				scan_alm_q <= '0;
			end else if (cmd.scan_rd) begin
				if (scan_alm_q == ALM_W'(ALARMS_PER_OWNER - 1)) begin
					scan_alm_q <= '0;
					scan_own_q <= scan_own_q + OWN_W'(1);
				end else begin
					scan_alm_q <= scan_alm_q + ALM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		own_s1 <= scan_own_q;
		alm_s1 <= scan_alm_q;
	end

	// due and better than the running winner; older arming wins a tie
	assign age    = counter_q - rd_stamp;
	assign cand   = rd_vld_s1 && armed_q[slot_of(own_s1, alm_s1)] && (rd_dl < item_q.now);
	assign better = !best_vld_q || (rd_dl < best_dl_q) ||
	                ((rd_dl == best_dl_q) && (age > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (cmd.scan_init) begin
			best_vld_q <= 1'b0;
		end else if (cand && better) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_init && cand && better) begin
			best_own_q <= own_s1;
			best_alm_q <= alm_s1;
			best_dl_q  <= rd_dl;
			best_age_q <= age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			fire_cnt_q <= '0;
		end else if (cmd.load) begin
			pend_vld_q <= 1'b0;
			fire_cnt_q <= '0;
		end else if (cmd.fire) begin
			pend_vld_q <= 1'b1;
			fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			pend_own_q <= best_own_q;
			pend_alm_q <= best_alm_q;
			pend_dl_q  <= best_dl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= 1'b0;
		end else begin
			fired_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.fired_owner    <= 3'(pend_own_q);
			result_q.fired_alarm    <= 2'(pend_alm_q);
			result_q.fired_deadline <= pend_dl_q;
			result_q.last           <= cmd.emit_last;
		end
	end

	assign fired  = fired_q;
	assign result = result_q;

	assign status.kind          = item_q.kind;
	assign status.addr_ok       = addr_ok;
	assign status.slot_armed    = armed_q[slot];
	assign status.scan_last     = scan_last;
	assign status.best_valid    = best_vld_q;
	assign status.fire_at_limit = (fire_cnt_q == FIRE_CNT_W'(MAX_FIRE - 1));
	assign status.pend_valid    = pend_vld_q;

endmodule

// ----- design/alarm_timer_queue_core.sv -----
// Top level of the alarm timer queue: controller and datapath.
//
// A table of one-shot alarms, one slot per owner and alarm number. A command
// transfers when start is high and busy is low. Arm and disarm keep busy high
// only in the dispatch state. Add and subtract time on an armed slot also pass
// a shift state (read, then write back the slot memory); on an idle one they
// end after dispatch. An update walks every slot through the single read port
// of the slot memory, one slot a cycle, and picks the earliest due alarm; each
// pass is the scan, a drain state and a pass-end state. Every fired alarm
// takes one pass, plus one last pass that finds nothing, unless the limit of
// 32 fires is hit, which ends the update through a final state instead. Each
// fired alarm is a one-cycle transfer on result, marked by fired; the receiver
// cannot stall, and the final one of an update carries last. The last result
// may appear in the cycle after busy falls. No clearing pass is needed after
// reset.
module alarm_timer_queue_core #(
	parameter int OWNERS           = 8,
	parameter int ALARMS_PER_OWNER = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  atq_pkg::in_item_t  item,
	output logic               fired,
	output atq_pkg::out_item_t result
);
	import atq_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing: dispatch, read-modify-write and scan passes
	atq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot memory, armed bits, arming counter and the running minimum
	atq_dp #(
		.OWNERS           (OWNERS),
		.ALARMS_PER_OWNER (ALARMS_PER_OWNER)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.fired  (fired),
		.result (result)
	);

endmodule

// ----- design/atq_checker.sv -----
// Port-level assertions of the alarm timer queue and their binding.
module atq_checker #(
	parameter int OWNERS           = 8,
	parameter int ALARMS_PER_OWNER = 4
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input atq_pkg::in_item_t  item,
	input logic               fired,
	input atq_pkg::out_item_t result
);
	import atq_pkg::*;

	// more results of this update follow, so the block is still working
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fired && !result.last |-> busy)
		else $error("non-final result while idle");

	// nothing follows directly after the final result
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		fired && result.last |=> !fired)
		else $error("result right after final result");

	// only updates produce results
	a_no_fire_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.kind != KIND_UPDATE) |=> !fired ##1 !fired)
		else $error("result after a non-update command");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		fired |-> (int'(result.fired_alarm) < ALARMS_PER_OWNER) &&
		          (int'(result.fired_owner) < OWNERS))
		else $error("fired slot out of range");

endmodule

bind alarm_timer_queue_core atq_checker #(
	.OWNERS           (OWNERS),
	.ALARMS_PER_OWNER (ALARMS_PER_OWNER)
) u_atq_checker (.*);

// ----- test/alarm_timer_queue_core_tb.sv -----
// Self-checking testbench for the alarm timer queue core.
module alarm_timer_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atq_pkg::*;

	localparam int OWNERS       = 8;
	localparam int ALARMS       = 4;
	localparam int SLOTS        = OWNERS * ALARMS;
	localparam int TOTAL_ITEMS  = 450;
	localparam int SETTLE_CYC   = 40;
	// Worst case is a full 32-fire update plus gap for each of ~480 commands,
	// roughly 10.6 ms; take several times that.
	localparam int unsigned LIMIT_NS = 60_000_000;
	// Top of the 3-bit kind field; codes above KIND_UPDATE are unused.
	localparam logic [2:0] KIND_LAST_CODE = 3'd7;

	typedef struct {
		in_item_t    cmd;
		int unsigned gap;   // idle cycles before the command goes out
		bit          drain; // hold until every pending fire has come out
	} queued_cmd_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  item = '0;
	logic      fired;
	out_item_t result;

	// Commands waiting for the driver, and fires still owed by the block.
	queued_cmd_t cmd_backlog[$];
	out_item_t   due_fires[$];

	// Shadow copy of the alarm table.
	logic [31:0] alarm_due   [SLOTS];
	logic        alarm_live  [SLOTS];
	logic [31:0] alarm_stamp [SLOTS];
	logic [31:0] stamp_count;

	// Stimulus shaping.
	bit          calm;
	bit          hold_next;
	int          n_posted;
	int          mismatches;

	// Driver pacing.
	bit          gap_loaded;
	int unsigned gap_left;

	alarm_timer_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.fired  (fired),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] wide;
		wide = {1'b0, a} + {1'b0, b};
		return wide[32] ? TICK_MAX : wide[31:0];
	endfunction

	// Apply one accepted command to the shadow table; an update queues the
	// fires it causes, earliest deadline first, older arming first on ties.
	task automatic advance_alarm_table(input in_item_t c);
		int          slot;
		int          pick;
		int          n_fire;
		logic [4:0]  pick_idx;
		out_item_t   held;
		bit          have_held;
		slot = int'({c.owner, c.alarm_number});
		have_held = 0;
		held = '0;
		n_fire = 0;
		case (c.kind)
			KIND_ARM: begin
				alarm_due[slot]   = sat_sum(c.now, c.amount);
				alarm_live[slot]  = 1'b1;
				alarm_stamp[slot] = stamp_count;
				stamp_count       = stamp_count + 32'd1;
			end
			KIND_DISARM: alarm_live[slot] = 1'b0;
			KIND_ADD, KIND_SUB: begin
				// idle slot: nothing moves, no restamp
				if (alarm_live[slot]) begin
					if (c.kind == KIND_ADD)
						alarm_due[slot] = sat_sum(alarm_due[slot], c.amount);
					else
						alarm_due[slot] = (c.amount > alarm_due[slot]) ? 32'd0
							: alarm_due[slot] - c.amount;
					alarm_stamp[slot] = stamp_count;
					stamp_count       = stamp_count + 32'd1;
				end
			end
			KIND_UPDATE: begin
				while (n_fire < MAX_FIRE) begin
					pick = -1;
					for (int s = 0; s < SLOTS; s++) begin
						if (!alarm_live[s] || alarm_due[s] >= c.now)
							continue;
						// age measured from the counter stays right across its wrap
						if (pick < 0 || alarm_due[s] < alarm_due[pick] ||
						    (alarm_due[s] == alarm_due[pick] &&
						     (stamp_count - alarm_stamp[s]) >
						     (stamp_count - alarm_stamp[pick])))
							pick = s;
					end
					if (pick < 0)
						break;
					alarm_live[pick] = 1'b0;
					// push one behind so the final fire can carry last
					if (have_held)
						due_fires.push_back(held);
					pick_idx             = pick[4:0];
					held.fired_owner     = pick_idx[4:2];
					held.fired_alarm     = pick_idx[1:0];
					held.fired_deadline  = alarm_due[pick];
					held.last            = 1'b0;
					have_held            = 1;
					n_fire++;
				end
				if (have_held) begin
					held.last = 1'b1;
					due_fires.push_back(held);
				end
			end
			default: ; // unused kinds are dropped
		endcase
	endtask

	task automatic post_cmd(input logic [2:0] kind, input logic [2:0] owner,
	                        input logic [1:0] alarm, input logic [31:0] amount,
	                        input logic [31:0] now);
		queued_cmd_t q;
		q.cmd.kind         = kind;
		q.cmd.owner        = owner;
		q.cmd.alarm_number = alarm;
		q.cmd.amount       = amount;
		q.cmd.now          = now;
		q.gap              = calm ? 0 : $urandom_range(0, 7);
		q.drain            = hold_next;
		hold_next          = 0;
		cmd_backlog.push_back(q);
		n_posted++;
	endtask

	function automatic logic [31:0] draw_amount();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return TICK_MAX;
			2:       return $urandom();
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	// Driver: a command transfers on an edge with start high and busy low.
	// The next one goes out on that same edge when its gap is zero, so start
	// is only ever assigned once per edge.
	always @(posedge clk or negedge arst_n) begin
		in_item_t    next_item;
		logic        next_start;
		queued_cmd_t head;
		if (!arst_n) begin
			start      <= 1'b0;
			item       <= '0;
			gap_loaded = 0;
			gap_left   = 0;
		end else begin
			next_start = start;
			next_item  = item;
			if (start && !busy) begin
				advance_alarm_table(item);
				next_start = 1'b0;
			end
			if (!next_start && cmd_backlog.size() != 0) begin
				if (!gap_loaded) begin
					gap_left   = cmd_backlog[0].gap;
					gap_loaded = 1;
				end
				if (gap_left != 0)
					gap_left--;
				else if (!(cmd_backlog[0].drain && (due_fires.size() != 0 || busy))) begin
					head       = cmd_backlog.pop_front();
					next_item  = head.cmd;
					next_start = 1'b1;
					gap_loaded = 0;
				end
			end
			start <= next_start;
			item  <= next_item;
		end
	end

	// Monitor: each fire is a one-cycle transfer; check it against the oldest
	// fire still owed.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if ($isunknown(fired)) begin
				$error("fired strobe is unknown");
				mismatches++;
			end else if (fired) begin
				if (due_fires.size() == 0) begin
					$error("fire with none owed: owner %0d alarm %0d deadline %0d",
						result.fired_owner, result.fired_alarm, result.fired_deadline);
					mismatches++;
				end else begin
					want = due_fires.pop_front();
					if (result.fired_owner !== want.fired_owner) begin
						$error("fired_owner: expected %0d, got %0d",
							want.fired_owner, result.fired_owner);
						mismatches++;
					end
					if (result.fired_alarm !== want.fired_alarm) begin
						$error("fired_alarm: expected %0d, got %0d",
							want.fired_alarm, result.fired_alarm);
						mismatches++;
					end
					if (result.fired_deadline !== want.fired_deadline) begin
						$error("fired_deadline: expected %0d, got %0d",
							want.fired_deadline, result.fired_deadline);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [31:0] tick_base;
		logic [31:0] fill_base;
		logic [4:0]  slot_idx;
		logic [2:0]  op;
		int          scenario;
		int          n_batch;
		int          fills;

		for (int s = 0; s < SLOTS; s++) begin
			alarm_due[s]   = '0;
			alarm_live[s]  = 1'b0;
			alarm_stamp[s] = '0;
		end
		stamp_count = '0;
		mismatches  = 0;
		n_posted    = 0;
		hold_next   = 0;
		fills       = 0;
		calm        = 0;

		// --- directed part ---
		post_cmd(KIND_UPDATE, 3'd0, 2'd0, 32'd0, TICK_MAX);     // empty table
		post_cmd(KIND_ARM,    3'd0, 2'd0, 32'd5, 32'd10);        // due 15
		post_cmd(KIND_ARM,    3'd7, 2'd3, TICK_MAX, 32'd2);      // arm saturates
		post_cmd(KIND_ARM,    3'd3, 2'd1, 32'd0, 32'd100);       // zero delay
		// three alarms landing on 50, armed in this order
		post_cmd(KIND_ARM,    3'd2, 2'd2, 32'd50, 32'd0);
		post_cmd(KIND_ARM,    3'd4, 2'd0, 32'd40, 32'd10);
		post_cmd(KIND_ARM,    3'd6, 2'd1, 32'd30, 32'd20);
		post_cmd(KIND_ADD,    3'd2, 2'd2, 32'd0, 32'd0);         // restamp: now newest
		post_cmd(KIND_SUB,    3'd3, 2'd1, 32'd200, 32'd0);       // clamps at zero
		post_cmd(KIND_ADD,    3'd0, 2'd0, 32'hFFFF_FFF0, 32'd0); // reaches top exactly
		// idle slot: shifts and disarm do nothing
		post_cmd(KIND_ADD,    3'd5, 2'd2, 32'd7, 32'd0);
		post_cmd(KIND_SUB,    3'd5, 2'd2, 32'd7, 32'd0);
		post_cmd(KIND_DISARM, 3'd5, 2'd2, 32'd0, 32'd0);
		post_cmd(KIND_DISARM, 3'd6, 2'd1, 32'd0, 32'd0);
		for (int k = KIND_UPDATE + 1; k <= KIND_LAST_CODE; k++)
			post_cmd(k[2:0], 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
				$urandom(), $urandom());
		// rearm replaces the earlier deadline
		post_cmd(KIND_ARM,    3'd1, 2'd2, 32'd3, 32'd5);
		post_cmd(KIND_ARM,    3'd1, 2'd2, 32'd20, 32'd5);
		hold_next = 1;
		post_cmd(KIND_UPDATE, 3'd0, 2'd0, 32'd0, 32'd50);        // 3/1 then 1/2
		post_cmd(KIND_UPDATE, 3'd0, 2'd0, 32'd0, 32'd51);        // tie: 4/0 then 2/2
		post_cmd(KIND_UPDATE, 3'd0, 2'd0, 32'd0, TICK_MAX);      // top deadlines never due
		post_cmd(KIND_DISARM, 3'd0, 2'd0, 32'd0, 32'd0);
		post_cmd(KIND_DISARM, 3'd7, 2'd3, 32'd0, 32'd0);

		// --- random part: mostly arm/shift batches closed by an update ---
		tick_base = 32'd1000;
		while (n_posted < TOTAL_ITEMS) begin
			calm     = ($urandom_range(0, 3) == 0);
			scenario = $urandom_range(0, 19);
			if ($urandom_range(0, 14) == 0)
				tick_base = $urandom();
			if (scenario < 12) begin
				n_batch = $urandom_range(1, 8);
				for (int i = 0; i < n_batch; i++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: op = KIND_ARM;
						5:             op = KIND_ADD;
						6:             op = KIND_SUB;
						default:       op = KIND_DISARM;
					endcase
					post_cmd(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
						draw_amount(), tick_base + $urandom_range(0, 10));
				end
				tick_base = tick_base + $urandom_range(0, 60);
				if ($urandom_range(0, 5) == 0)
					hold_next = 1;
				post_cmd(KIND_UPDATE, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					$urandom(), tick_base);
			end else if (scenario < 14 && fills < 3) begin
				// arm every slot with few distinct deadlines, then fire them all
				fills++;
				fill_base = $urandom_range(0, 32'h7FFF_FFFF);
				for (int s = 0; s < SLOTS; s++) begin
					slot_idx = s[4:0];
					post_cmd(KIND_ARM, slot_idx[4:2], slot_idx[1:0],
						$urandom_range(0, 7), fill_base);
				end
				post_cmd(KIND_UPDATE, 3'd0, 2'd0, 32'd0, fill_base + 32'd20);
			end else if (scenario < 17) begin
				post_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					2'($urandom_range(0, 3)), $urandom(), $urandom());
			end else begin
				post_cmd(KIND_UPDATE, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					$urandom(), $urandom());
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || busy || due_fires.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);

		if (mismatches == 0 && due_fires.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
